>>> src/qowm_pkg.sv
`timescale 1ns / 1ps

package qowm_pkg;

   localparam int NUM_WHEELS    = 4;
   localparam int WHEEL_IDX_W   = $clog2(NUM_WHEELS);
   localparam int SPEED_W       = 15;
   localparam int FIELD_W       = 16;
   localparam int REQ_TYPE_W    = 3;
   localparam int MAG_W         = 16;
   localparam int ANGLE_W       = 16;

   localparam int SINE_BITS_DEF = 16;
   localparam int SINE_BITS_MAX = 24;
   localparam int SINE_LAT      = 5;
   localparam int PIPE_DEPTH    = SINE_LAT + 1 + NUM_WHEELS;

   // fixed point widths of the sine polynomial
   localparam int Q30         = 30;
   localparam int SINE_SHIFT  = Q30 + 15;
   localparam int ZQ_W        = 31;
   localparam int C_W         = 27;
   localparam int T_W         = 30;
   localparam int T2_W        = 31;
   localparam int PROD_W      = SPEED_W + MAG_W;

   localparam logic [T2_W-1:0]    Q30_A         = 31'd1686629713;
   localparam logic [T_W-1:0]     Q30_B         = 30'd688904866;
   localparam logic [C_W-1:0]     Q30_C         = 27'd76017977;
   localparam logic [SPEED_W-1:0] INV_SQRT2_Q15 = 15'd23170;
   localparam logic [SPEED_W-1:0] SINE_MAX      = 15'h7FFF;
   localparam logic [ANGLE_W-1:0] EIGHTH_TURN   = 16'h2000;
   localparam logic [MAG_W-1:0]   MAG_FULL      = 16'h8000;
   localparam logic [FIELD_W-1:0] FIELD_MIN     = 16'h8000;
   localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 15'h7FFF;

   localparam int CSR_ADDR_W = WHEEL_IDX_W + 2;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_POLAR      = 3'd0,
      REQ_FORWARD    = 3'd1,
      REQ_BACKWARD   = 3'd2,
      REQ_LEFT       = 3'd3,
      REQ_RIGHT      = 3'd4,
      REQ_TURN_LEFT  = 3'd5,
      REQ_TURN_RIGHT = 3'd6
   } req_code_type;

   typedef logic [NUM_WHEELS-1:0][FIELD_W-1:0] res_vec_type;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic [MAG_W-1:0]      mag;
      logic [FIELD_W-1:0]    abs_speed;
   } front_tok_type;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic [FIELD_W-1:0]    abs_speed;
      logic [PROD_W-1:0]     prod_m;
      logic [PROD_W-1:0]     prod_p;
      logic                  sm_neg;
      logic                  sm_pos;
      logic                  sp_neg;
      logic                  sp_pos;
   } cell_tok_type;

   // sign pattern of the fixed modes, one bit per wheel
   function automatic logic fixed_neg(input logic [REQ_TYPE_W-1:0] req,
                                      input logic [WHEEL_IDX_W-1:0] wheel);
      logic [NUM_WHEELS-1:0] mask;
      case (req_code_type'(req))
         REQ_FORWARD:    mask = 4'b0110;
         REQ_BACKWARD:   mask = 4'b1001;
         REQ_LEFT:       mask = 4'b1100;
         REQ_RIGHT:      mask = 4'b0011;
         REQ_TURN_RIGHT: mask = 4'b1111;
         default:        mask = 4'b0000;
      endcase
      return mask[wheel];
   endfunction

endpackage

>>> src/qowm_req_if.sv
`timescale 1ns / 1ps

interface qowm_req_if;
   import qowm_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [REQ_TYPE_W-1:0]     req_type;
   logic [MAG_W-1:0]          magnitude;
   logic [ANGLE_W-1:0]        angle;
   logic signed [FIELD_W-1:0] speed;

   modport source (output valid, req_type, magnitude, angle, speed, input ready);
   modport sink   (input valid, req_type, magnitude, angle, speed, output ready);
endinterface

>>> src/qowm_rsp_if.sv
`timescale 1ns / 1ps

interface qowm_rsp_if;
   import qowm_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] target_wheel0;
   logic signed [FIELD_W-1:0] target_wheel1;
   logic signed [FIELD_W-1:0] target_wheel2;
   logic signed [FIELD_W-1:0] target_wheel3;

   modport source (output valid, target_wheel0, target_wheel1, target_wheel2, target_wheel3,
                   input ready);
   modport sink   (input valid, target_wheel0, target_wheel1, target_wheel2, target_wheel3,
                   output ready);
endinterface

>>> src/quad_omni_wheel_mixer_unit.sv
`timescale 1ns / 1ps

// channel   dir   handshake          payload
// req_if    in    valid / ready      req_type, magnitude, angle, speed
// rsp_if    out   valid / ready      target_wheel0 .. target_wheel3
// apb       in    psel / penable     paddr, pwdata, prdata (max_speed_wheel0..3)
//
// one transaction per cycle while rsp_if does not stall; the pipeline runs through the sine
// polynomial stages (four dependent multiplies), the sine by magnitude product, and one
// wheel cell per wheel in the row of four.
// every stage advances when empty or when the next one moves, so bubbles close up
// and req_if stays ready while a result waits in the last cell until all ten
// stages hold a transaction.
// reset is synchronous: valid bits clear and every wheel limit returns to 32767.

module quad_omni_wheel_mixer_unit #(
   parameter int SINE_BITS = qowm_pkg::SINE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   qowm_req_if.sink                          req_if,
   qowm_rsp_if.source                        rsp_if,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [qowm_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [qowm_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [qowm_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import qowm_pkg::*;

   logic [SPEED_W-1:0]      max_speed_ff [NUM_WHEELS];
   logic [WHEEL_IDX_W-1:0]  csr_index;
   logic                    csr_write;

   logic [PIPE_DEPTH-1:0]   pipe_valid;
   logic [PIPE_DEPTH-1:0]   stage_en;
   logic                    req_accept;

   logic [ANGLE_W-1:0]      phase_m;
   logic [ANGLE_W-1:0]      phase_p;
   logic [SPEED_W-1:0]      sine_mag_m, sine_mag_p;
   logic                    sine_neg_m, sine_neg_p;

   logic [SINE_LAT-1:0]     front_valid_ff;
   logic [SINE_LAT-1:0]     front_valid_in;
   front_tok_type           front_tok_ff [SINE_LAT];
   front_tok_type           front_tok_in [SINE_LAT];
   front_tok_type           front_last;

   logic                    mix_valid_ff;
   cell_tok_type            mix_tok_ff;
   cell_tok_type            mix_tok_in;

   logic [NUM_WHEELS:0]     chain_valid;
   cell_tok_type            chain_tok [NUM_WHEELS+1];
   res_vec_type             chain_res [NUM_WHEELS+1];

   // configuration port
   assign csr_index = paddr[CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign prdata    = CSR_DATA_W'(max_speed_ff[csr_index]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_WHEELS; i++) begin
            max_speed_ff[i] <= MAX_SPEED_RST;
         end
      end else if (csr_write) begin
         max_speed_ff[csr_index] <= pwdata[SPEED_W-1:0];
      end
   end

   // stall chain: a stage loads when empty or when the stage after it moves
   assign pipe_valid = {chain_valid[NUM_WHEELS:1], mix_valid_ff, front_valid_ff};

   always_comb begin
      stage_en[PIPE_DEPTH-1] = !pipe_valid[PIPE_DEPTH-1] || rsp_if.ready;
      for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
         stage_en[i] = !pipe_valid[i] || stage_en[i+1];
      end
   end

   assign req_if.ready = stage_en[0] && !reset;
   assign req_accept   = req_if.valid && req_if.ready;

   // sines at angle minus and plus an eighth turn
   assign phase_m = req_if.angle - EIGHTH_TURN;
   assign phase_p = req_if.angle + EIGHTH_TURN;

   qowm_sine #(.SINE_BITS(SINE_BITS)) u_sine_m (
      .clock    (clock),
      .stage_en (stage_en[SINE_LAT-1:0]),
      .phase    (phase_m),
      .sine_mag (sine_mag_m),
      .sine_neg (sine_neg_m)
   );

   qowm_sine #(.SINE_BITS(SINE_BITS)) u_sine_p (
      .clock    (clock),
      .stage_en (stage_en[SINE_LAT-1:0]),
      .phase    (phase_p),
      .sine_mag (sine_mag_p),
      .sine_neg (sine_neg_p)
   );

   // command fields ride alongside the sine stages
   always_comb begin
      front_valid_in = {front_valid_ff[SINE_LAT-2:0], req_accept};
      front_tok_in[0].req_type  = req_if.req_type;
      front_tok_in[0].mag       = (req_if.magnitude > MAG_FULL) ? MAG_FULL : req_if.magnitude;
      front_tok_in[0].abs_speed = req_if.speed[FIELD_W-1] ? FIELD_W'(-req_if.speed)
                                : FIELD_W'(req_if.speed);
      for (int i = 1; i < SINE_LAT; i++) begin
         front_tok_in[i] = front_tok_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= '0;
      end else begin
         for (int i = 0; i < SINE_LAT; i++) begin
            if (stage_en[i]) begin
               front_valid_ff[i] <= front_valid_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SINE_LAT; i++) begin
         if (stage_en[i]) begin
            front_tok_ff[i] <= front_tok_in[i];
         end
      end
   end

   // sine by magnitude, shared by the wheel pairs
   assign front_last = front_tok_ff[SINE_LAT-1];

   always_comb begin
      mix_tok_in.req_type  = front_last.req_type;
      mix_tok_in.abs_speed = front_last.abs_speed;
      mix_tok_in.prod_m    = sine_mag_m * front_last.mag;
      mix_tok_in.prod_p    = sine_mag_p * front_last.mag;
      mix_tok_in.sm_neg    = sine_neg_m && (sine_mag_m != '0);
      mix_tok_in.sm_pos    = !sine_neg_m && (sine_mag_m != '0);
      mix_tok_in.sp_neg    = sine_neg_p && (sine_mag_p != '0);
      mix_tok_in.sp_pos    = !sine_neg_p && (sine_mag_p != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_valid_ff <= 1'b0;
      end else if (stage_en[SINE_LAT]) begin
         mix_valid_ff <= front_valid_ff[SINE_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[SINE_LAT]) begin
         mix_tok_ff <= mix_tok_in;
      end
   end

   // row of wheel cells, each fills its own slot of the result
   assign chain_valid[0] = mix_valid_ff;
   assign chain_tok[0]   = mix_tok_ff;
   assign chain_res[0]   = '0;

   for (genvar k = 0; k < NUM_WHEELS; k++) begin : g_cell
      qowm_cell #(.WHEEL(k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (stage_en[SINE_LAT+1+k]),
         .up_valid  (chain_valid[k]),
         .up_tok    (chain_tok[k]),
         .up_res    (chain_res[k]),
         .max_speed (max_speed_ff[k]),
         .dn_valid  (chain_valid[k+1]),
         .dn_tok    (chain_tok[k+1]),
         .dn_res    (chain_res[k+1])
      );
   end

   assign rsp_if.valid         = chain_valid[NUM_WHEELS];
   assign rsp_if.target_wheel0 = chain_res[NUM_WHEELS][0];
   assign rsp_if.target_wheel1 = chain_res[NUM_WHEELS][1];
   assign rsp_if.target_wheel2 = chain_res[NUM_WHEELS][2];
   assign rsp_if.target_wheel3 = chain_res[NUM_WHEELS][3];

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("result valid right after reset");

   a_no_min_field: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.target_wheel0 != FIELD_MIN) && (rsp_if.target_wheel1 != FIELD_MIN)
                    && (rsp_if.target_wheel2 != FIELD_MIN) && (rsp_if.target_wheel3 != FIELD_MIN))
      else $error("wheel target at most negative code");

   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && (chain_tok[NUM_WHEELS].req_type > REQ_TURN_RIGHT)
         |-> chain_res[NUM_WHEELS] == '0)
      else $error("unused command gave nonzero targets");

endmodule

>>> src/qowm_sine.sv
`timescale 1ns / 1ps

module qowm_sine #(
   parameter int SINE_BITS = qowm_pkg::SINE_BITS_DEF
) (
   input  logic                             clock,
   input  logic [qowm_pkg::SINE_LAT-1:0]    stage_en,
   input  logic [qowm_pkg::ANGLE_W-1:0]     phase,
   output logic [qowm_pkg::SPEED_W-1:0]     sine_mag,
   output logic                             sine_neg
);
   import qowm_pkg::*;

   localparam int WIDE_W = ANGLE_W + SINE_BITS_MAX;
   localparam int FRAC_W = SINE_BITS - 2;
   localparam int PAD_W  = ZQ_W - FRAC_W - 1;

   logic [WIDE_W-1:0]       phase_wide;
   logic [SINE_BITS-1:0]    phase_scaled;
   logic [1:0]              quad;
   logic [FRAC_W:0]         z_raw;
   logic [FRAC_W:0]         z_fold;
   logic [ZQ_W-1:0]         zq_in;

   logic [2*ZQ_W-1:0]       sq;
   logic [ZQ_W+C_W-1:0]     mul_c;
   logic [ZQ_W+T_W-1:0]     mul_t;
   logic [ZQ_W+T2_W-1:0]    mul_s;
   logic [T_W-1:0]          t_in;
   logic [T2_W-1:0]         t2_in;
   logic [SPEED_W-1:0]      s_in;

   logic [ZQ_W-1:0]         zq1_ff, zq2_ff, zq3_ff, zq4_ff;
   logic [ZQ_W-1:0]         z2_ff, z2b_ff;
   logic [T_W-1:0]          t_ff;
   logic [T2_W-1:0]         t2_ff;
   logic [SPEED_W-1:0]      s_ff;
   logic [SINE_LAT-1:0]     neg_ff;

   // rescale the phase to SINE_BITS, then fold into one quarter wave
   assign phase_wide   = {phase, SINE_BITS_MAX'(0)};
   assign phase_scaled = phase_wide[WIDE_W-1 -: SINE_BITS];
   assign quad         = phase_scaled[SINE_BITS-1 -: 2];
   assign z_raw        = {1'b0, phase_scaled[FRAC_W-1:0]};
   assign z_fold       = quad[0] ? ({1'b1, FRAC_W'(0)} - z_raw) : z_raw;
   assign zq_in        = {z_fold, PAD_W'(0)};

   always_comb begin
      sq    = zq1_ff * zq1_ff;
      mul_c = z2_ff * Q30_C;
      t_in  = Q30_B - T_W'(mul_c[ZQ_W+C_W-1:Q30]);
      mul_t = z2b_ff * t_ff;
      t2_in = Q30_A - mul_t[ZQ_W+T_W-1:Q30];
      mul_s = zq4_ff * t2_ff;
      s_in  = (mul_s[ZQ_W+T2_W-1:SINE_SHIFT] > {2'b00, SINE_MAX}) ? SINE_MAX
            : mul_s[SINE_SHIFT+SPEED_W-1:SINE_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         zq1_ff    <= zq_in;
         neg_ff[0] <= quad[1];
      end
      if (stage_en[1]) begin
         z2_ff     <= sq[ZQ_W+Q30-1:Q30];
         zq2_ff    <= zq1_ff;
         neg_ff[1] <= neg_ff[0];
      end
      if (stage_en[2]) begin
         t_ff      <= t_in;
         z2b_ff    <= z2_ff;
         zq3_ff    <= zq2_ff;
         neg_ff[2] <= neg_ff[1];
      end
      if (stage_en[3]) begin
         t2_ff     <= t2_in;
         zq4_ff    <= zq3_ff;
         neg_ff[3] <= neg_ff[2];
      end
      if (stage_en[4]) begin
         s_ff      <= s_in;
         neg_ff[4] <= neg_ff[3];
      end
   end

   assign sine_mag = s_ff;
   assign sine_neg = neg_ff[SINE_LAT-1];

endmodule

>>> src/qowm_cell.sv
`timescale 1ns / 1ps

module qowm_cell #(
   parameter int WHEEL = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           up_valid,
   input  qowm_pkg::cell_tok_type         up_tok,
   input  qowm_pkg::res_vec_type          up_res,
   input  logic [qowm_pkg::SPEED_W-1:0]   max_speed,
   output logic                           dn_valid,
   output qowm_pkg::cell_tok_type         dn_tok,
   output qowm_pkg::res_vec_type          dn_res
);
   import qowm_pkg::*;

   logic [SPEED_W-1:0]         lim;
   logic [PROD_W-1:0]          polar_op;
   logic                       polar_neg;
   logic [PROD_W-1:0]          mul_a;
   logic [SPEED_W-1:0]         mul_b;
   logic [PROD_W+SPEED_W-1:0]  prod;
   logic [SPEED_W-1:0]         v;
   logic                       neg;
   logic [FIELD_W-1:0]         wheel_val;
   logic [FIELD_W-1:0]         res_abs;

   logic                       valid_ff;
   cell_tok_type               tok_ff;
   res_vec_type                res_ff;
   res_vec_type                res_in;

   always_comb begin
      case (WHEEL)
         0: begin
            polar_op  = up_tok.prod_m;
            polar_neg = up_tok.sm_neg;
         end
         1: begin
            polar_op  = up_tok.prod_p;
            polar_neg = up_tok.sp_pos;
         end
         2: begin
            polar_op  = up_tok.prod_m;
            polar_neg = up_tok.sm_pos;
         end
         default: begin
            polar_op  = up_tok.prod_p;
            polar_neg = up_tok.sp_neg;
         end
      endcase

      lim = ({1'b0, max_speed} > up_tok.abs_speed) ? up_tok.abs_speed[SPEED_W-1:0]
          : max_speed;

      // one shared multiplier: sine product by max_speed, or 0.7071 by limit
      mul_a = PROD_W'(INV_SQRT2_Q15);
      mul_b = lim;
      case (req_code_type'(up_tok.req_type))
         REQ_POLAR: begin
            mul_a = polar_op;
            mul_b = max_speed;
         end
         default: ;
      endcase
      prod = mul_a * mul_b;

      case (req_code_type'(up_tok.req_type))
         REQ_POLAR: begin
            v   = prod[Q30+SPEED_W-1:Q30];
            neg = polar_neg;
         end
         REQ_FORWARD, REQ_BACKWARD, REQ_LEFT, REQ_RIGHT: begin
            v   = prod[2*SPEED_W-1:SPEED_W];
            neg = fixed_neg(up_tok.req_type, WHEEL_IDX_W'(WHEEL));
         end
         REQ_TURN_LEFT, REQ_TURN_RIGHT: begin
            v   = lim;
            neg = fixed_neg(up_tok.req_type, WHEEL_IDX_W'(WHEEL));
         end
         default: begin
            v   = '0;
            neg = 1'b0;
         end
      endcase

      wheel_val = (neg && (v != '0)) ? -{1'b0, v} : {1'b0, v};

      res_in        = up_res;
      res_in[WHEEL] = wheel_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tok_ff <= up_tok;
         res_ff <= res_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_tok   = tok_ff;
   assign dn_res   = res_ff;

   assign res_abs = res_ff[WHEEL][FIELD_W-1] ? -res_ff[WHEEL] : res_ff[WHEEL];

   // no mode drives a wheel past its own limit
   a_within_limit: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> res_abs <= {1'b0, max_speed})
      else $error("wheel target exceeds its limit");

endmodule
